### sv/multicast_consumer_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Multicast consumer queue assertion macros
// Short forms for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef MULTICAST_CONSUMER_QUEUE_UNIT_ASSERT_SVH
`define MULTICAST_CONSUMER_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MCQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcq same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define MCQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcq next-cycle check failed");

`endif

### sv/mcq_pkg.sv
// ----------------------------------------------------------------------------
// Multicast consumer queue package
// Sizes, codes and beat types shared by the queue and its checker.
// ----------------------------------------------------------------------------
package mcq_pkg;

    // Sizing
    localparam int QUEUE_DEPTH   = 16;
    localparam int NUM_CONSUMERS = 8;
    localparam int DATA_WIDTH    = 32;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int CID_W         = 3;
    localparam int MASK_W        = 8;
    localparam int CAP_W         = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAP  = 2'd1;
    localparam logic [CAP_W-1:0]     CAP_RESET    = 5'd16;

    // Commands
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef logic [NUM_CONSUMERS-1:0] t_owed;
    typedef logic [PTR_W-1:0]         t_ptr;

    // Input beat
    typedef struct packed {
        logic                  cmd;
        logic [CID_W-1:0]      consumer_id;
        logic [DATA_WIDTH-1:0] payload;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic                  found;
        logic [DATA_WIDTH-1:0] data_out;
        logic                  add_refused;
        logic [CNT_W-1:0]      item_total;
        logic                  is_full;
        logic                  not_empty;
        logic [CNT_W-1:0]      pending_for_id;
    } t_out_item;

endpackage

### sv/multicast_consumer_queue_unit.sv
// ----------------------------------------------------------------------------
// Multicast consumer queue
// Bounded age-ordered queue whose entries are each read once by every
// consumer that was registered when the entry was added.
// ----------------------------------------------------------------------------
// The queue takes one item per clock cycle while its output is not stalled
// and returns its result beat through the pending-result registers and the
// result beat register; the data memory read is registered. Data words live
// in a 16 x 32 single-port-write, one-read memory addressed by slot; the
// per-entry owed masks and an age-ordered list of slot numbers sit in
// flip-flops, so removing an entry only shifts the list and masks while the
// data stays in place. Reset takes effect at once: no clearing pass is
// needed. Configuration writes are always ready.
module multicast_consumer_queue_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Item input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mcq_pkg::t_in_item                i_in_data,
    // Result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mcq_pkg::t_out_item               o_out_data,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mcq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH = mcq_pkg::QUEUE_DEPTH;

    // Configuration registers
    logic [mcq_pkg::MASK_W-1:0] r_cons_mask;
    logic [mcq_pkg::CAP_W-1:0]  r_cap_limit;
    logic [mcq_pkg::CNT_W-1:0]  cap_eff;

    // Queue state
    mcq_pkg::t_owed             r_owed [DEPTH];
    mcq_pkg::t_owed             n_owed [DEPTH];
    mcq_pkg::t_ptr              r_list [DEPTH];
    mcq_pkg::t_ptr              n_list [DEPTH];
    logic [mcq_pkg::CNT_W-1:0]  r_count;
    logic [mcq_pkg::CNT_W-1:0]  n_count;
    logic [mcq_pkg::DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [mcq_pkg::DATA_WIDTH-1:0] r_rd_data;

    // Pending result
    logic                       r_busy;
    logic                       r_found;
    logic                       r_refused;
    mcq_pkg::t_owed             r_bit;
    mcq_pkg::t_out_item         r_out;
    logic                       r_out_valid;

    // Step signals
    logic                       out_free;
    logic                       load;
    logic                       in_acc;
    logic                       is_get;
    mcq_pkg::t_owed             id_bit;
    mcq_pkg::t_owed             add_mask;
    logic [DEPTH-1:0]           hit;
    mcq_pkg::t_ptr              hit_pos;
    logic                       any_hit;
    mcq_pkg::t_owed             sel_new;
    mcq_pkg::t_ptr              cnt_idx;
    logic                       full_now;
    logic                       do_store;
    logic                       do_found;
    logic                       do_refuse;
    logic [mcq_pkg::CNT_W-1:0]  pend;

    // Handshakes
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load        = r_busy && out_free;
    assign o_in_stall  = r_busy && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Effective capacity, clipped to the depth
    assign cap_eff = (32'(r_cap_limit) > DEPTH) ? mcq_pkg::CNT_W'(DEPTH)
                                                : mcq_pkg::CNT_W'(r_cap_limit);

    // Consumer bit for this item; ids beyond the consumer count own nothing
    assign id_bit = (32'(i_in_data.consumer_id) < mcq_pkg::NUM_CONSUMERS)
                  ? (mcq_pkg::t_owed'(1) << i_in_data.consumer_id) : '0;
    assign add_mask = r_cons_mask[mcq_pkg::NUM_CONSUMERS-1:0];
    assign is_get   = (i_in_data.cmd == mcq_pkg::CMD_GET);

    // Oldest entry owed to the consumer
    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit[i] = |(r_owed[i] & id_bit);
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_pos = mcq_pkg::t_ptr'(i);
            end
        end
    end
    assign any_hit = |hit;
    assign sel_new = r_owed[hit_pos] & ~id_bit;

    // Add bookkeeping
    assign cnt_idx   = r_count[mcq_pkg::PTR_W-1:0];
    assign full_now  = (r_count >= cap_eff) || (r_count >= mcq_pkg::CNT_W'(DEPTH));
    assign do_refuse = in_acc && !is_get && full_now;
    assign do_store  = in_acc && !is_get && !full_now && (add_mask != '0);
    assign do_found  = in_acc && is_get && any_hit;

    // Next state of masks, slot list and count
    always_comb begin
        n_owed  = r_owed;
        n_list  = r_list;
        n_count = r_count;
        if (do_store) begin
            n_owed[cnt_idx] = add_mask;
            n_count         = r_count + mcq_pkg::CNT_W'(1);
        end else if (do_found) begin
            if (sel_new != '0) begin
                n_owed[hit_pos] = sel_new;
            end else begin
                // Remove: younger entries move up, freed slot goes to the back
                for (int j = 0; j < DEPTH - 1; j++) begin
                    if (mcq_pkg::t_ptr'(j) >= hit_pos) begin
                        n_owed[j] = r_owed[j+1];
                        n_list[j] = r_list[j+1];
                    end
                end
                n_owed[DEPTH-1] = '0;
                n_list[DEPTH-1] = r_list[hit_pos];
                n_count         = r_count - mcq_pkg::CNT_W'(1);
            end
        end
    end

    // Entries still owed to the consumer, counted after the step
    always_comb begin
        pend = '0;
        for (int i = 0; i < DEPTH; i++) begin
            pend = pend + mcq_pkg::CNT_W'(|(r_owed[i] & r_bit));
        end
    end

    // Data memory: write on add, read the hit slot on get
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_mem[r_list[cnt_idx]] <= i_in_data.payload;
        end
        if (do_found) begin
            r_rd_data <= r_mem[r_list[hit_pos]];
        end
    end

    // Queue state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_owed[i] <= '0;
                r_list[i] <= mcq_pkg::t_ptr'(i);
            end
            r_count <= '0;
        end else begin
            r_owed  <= n_owed;
            r_list  <= n_list;
            r_count <= n_count;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cons_mask <= '0;
            r_cap_limit <= mcq_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mcq_pkg::CFG_IDX_MASK: r_cons_mask <= i_cfg_data[mcq_pkg::MASK_W-1:0];
                mcq_pkg::CFG_IDX_CAP:  r_cap_limit <= i_cfg_data[mcq_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Step flags held for the result beat
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_found   <= do_found;
            r_refused <= do_refuse;
            r_bit     <= id_bit;
        end
    end

    // Control: pending result and output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (load) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.found          <= r_found;
            r_out.data_out       <= r_found ? r_rd_data : '0;
            r_out.add_refused    <= r_refused;
            r_out.item_total     <= r_count;
            r_out.is_full        <= (r_count >= cap_eff);
            r_out.not_empty      <= (r_count != '0);
            r_out.pending_for_id <= pend;
        end
    end

endmodule

### sv/mcq_checker.sv
// ----------------------------------------------------------------------------
// Multicast consumer queue port checker
// Checks result consistency and output hold behaviour at the top-level ports.
// ----------------------------------------------------------------------------
`include "multicast_consumer_queue_unit_assert.svh"

module mcq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input mcq_pkg::t_out_item  o_out_data
);

    // Not-empty flag agrees with the item count
    `MCQ_ASSERT_IMP(a_not_empty, i_clk, i_rst_n, o_out_valid, o_out_data.not_empty == (o_out_data.item_total != '0))

    // A refused add only happens on a full queue
    `MCQ_ASSERT_IMP(a_refuse_full, i_clk, i_rst_n, o_out_valid && o_out_data.add_refused, o_out_data.is_full)

    // Pending entries never exceed held entries
    `MCQ_ASSERT_IMP(a_pend_le_total, i_clk, i_rst_n, o_out_valid, o_out_data.pending_for_id <= o_out_data.item_total)

    // A stalled result beat holds
    `MCQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind multicast_consumer_queue_unit mcq_checker u_mcq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/mcq_result_checker.sv
// ----------------------------------------------------------------------------
// Multicast consumer queue result checker
// Watches the item, result and configuration channels of the queue, keeps a
// shadow copy of the queue contents and settings, predicts the status beat
// for every accepted item and compares each accepted result beat with it.
// ----------------------------------------------------------------------------
module mcq_result_checker
    import mcq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Item channel
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    // Result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    // Configuration channel
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Verdict side
    output int                    o_fail_count,
    output int                    o_outstanding
);

    // Shadow queue contents, oldest entry at index 0
    t_owed                 sh_owed [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] sh_data [QUEUE_DEPTH];
    int                    sh_count;
    // Shadow settings
    t_owed                 sh_mask;
    logic [CAP_W-1:0]      sh_cap;

    // Status beats owed by the queue, oldest first
    t_out_item             status_q [$];
    int                    reported;
    int                    beat_no;

    // Apply one add or get to the shadow queue and work out its status beat
    task automatic serve_request(input t_in_item req, output t_out_item r);
        int    eff_cap;
        int    hit;
        int    i;
        int    owed_cnt;
        t_owed want;
        r        = '0;
        eff_cap  = (int'(sh_cap) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(sh_cap);
        want     = (int'(req.consumer_id) < NUM_CONSUMERS) ?
                   (t_owed'(1) << req.consumer_id) : '0;
        if (req.cmd == CMD_ADD) begin
            if (sh_count >= eff_cap) begin
                r.add_refused = 1'b1;
            end else if (sh_mask != '0) begin
                // registered consumers: accepted and stored with the current mask
                sh_owed[sh_count] = sh_mask;
                sh_data[sh_count] = req.payload;
                sh_count++;
            end
        end else if (want != '0) begin
            hit = -1;
            for (i = 0; i < sh_count; i++)
                if (hit < 0 && (sh_owed[i] & want) != '0)
                    hit = i;
            if (hit >= 0) begin
                r.found    = 1'b1;
                r.data_out = sh_data[hit];
                sh_owed[hit] &= ~want;
                // last reader gone: close the gap, age order kept
                if (sh_owed[hit] == '0) begin
                    for (i = hit; i < sh_count - 1; i++) begin
                        sh_owed[i] = sh_owed[i+1];
                        sh_data[i] = sh_data[i+1];
                    end
                    sh_count--;
                    sh_owed[sh_count] = '0;
                end
            end
        end
        owed_cnt = 0;
        for (i = 0; i < sh_count; i++)
            if ((sh_owed[i] & want) != '0)
                owed_cnt++;
        r.item_total     = CNT_W'(sh_count);
        r.is_full        = (sh_count >= eff_cap);
        r.not_empty      = (sh_count > 0);
        r.pending_for_id = CNT_W'(owed_cnt);
    endtask

    // Append one differing field to the mismatch note
    task automatic note_field(input string name, input logic [DATA_WIDTH-1:0] e,
                              input logic [DATA_WIDTH-1:0] a, inout string diffs);
        if (a !== e)
            diffs = {diffs, $sformatf(" %s exp %0h got %0h", name, e, a)};
    endtask

    // Compare a result beat with the oldest prediction, field by field
    task automatic check_status(input t_out_item e, input t_out_item a);
        string diffs;
        diffs = "";
        note_field("found", DATA_WIDTH'(e.found), DATA_WIDTH'(a.found), diffs);
        note_field("data_out", e.data_out, a.data_out, diffs);
        note_field("add_refused", DATA_WIDTH'(e.add_refused),
                   DATA_WIDTH'(a.add_refused), diffs);
        note_field("item_total", DATA_WIDTH'(e.item_total),
                   DATA_WIDTH'(a.item_total), diffs);
        note_field("is_full", DATA_WIDTH'(e.is_full), DATA_WIDTH'(a.is_full), diffs);
        note_field("not_empty", DATA_WIDTH'(e.not_empty),
                   DATA_WIDTH'(a.not_empty), diffs);
        note_field("pending_for_id", DATA_WIDTH'(e.pending_for_id),
                   DATA_WIDTH'(a.pending_for_id), diffs);
        if (diffs != "") begin
            o_fail_count++;
            if (reported < 10)
                $display("mismatch on result beat %0d:%s", beat_no, diffs);
            reported++;
        end
    endtask

    // Beat watcher: settings, then results, then new items
    initial begin : beat_watch
        t_out_item predicted;
        o_fail_count  = 0;
        o_outstanding = 0;
        reported      = 0;
        beat_no       = 0;
        sh_count      = 0;
        sh_mask       = '0;
        sh_cap        = CAP_RESET;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                for (int k = 0; k < QUEUE_DEPTH; k++)
                    sh_owed[k] = '0;
                sh_count = 0;
                sh_mask  = '0;
                sh_cap   = CAP_RESET;
                status_q.delete();
            end else begin
                if (i_cfg_valid && i_cfg_ready) begin
                    unique case (i_cfg_index)
                        CFG_IDX_MASK: sh_mask = i_cfg_data[MASK_W-1:0];
                        CFG_IDX_CAP:  sh_cap  = i_cfg_data[CAP_W-1:0];
                        default: ;
                    endcase
                end
                if (i_out_valid && !i_out_stall) begin
                    if (status_q.size() == 0) begin
                        o_fail_count++;
                        if (reported < 10)
                            $display("result beat %0d with nothing outstanding: %h",
                                     beat_no, i_out_data);
                        reported++;
                    end else begin
                        check_status(status_q.pop_front(), i_out_data);
                    end
                    beat_no++;
                end
                if (i_in_valid && !i_in_stall) begin
                    serve_request(i_in_data, predicted);
                    status_q = {status_q, predicted};
                end
            end
            o_outstanding = status_q.size();
        end
    end

endmodule

### tb/multicast_consumer_queue_unit_test.sv
// ----------------------------------------------------------------------------
// Multicast consumer queue testbench
// Drives directed and random add/get beats through the queue under several
// mask and capacity settings, with bursty sending and random output stalls;
// a checker beside the queue predicts and compares every status beat.
// ----------------------------------------------------------------------------
module multicast_consumer_queue_unit_test;
    import mcq_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 12;
    localparam int DRAIN_CYCLES  = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int                    fail_count;
    int                    outstanding;
    int                    cycle_count;
    int                    burst_left;
    int                    stall_run;
    int                    stall_style;
    logic [MASK_W-1:0]     cur_mask;

    multicast_consumer_queue_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mcq_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Receiver stalls: stretches of differing style, including none
    initial begin
        i_out_stall = 1'b0;
        stall_run   = 0;
        stall_style = 0;
        forever begin
            @(negedge i_clk);
            if (stall_run == 0) begin
                stall_style = $urandom_range(0, 4);
                stall_run   = $urandom_range(8, 60);
            end
            stall_run--;
            unique case (stall_style)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                3:       i_out_stall <= ((stall_run % 7) < 3);
                default: i_out_stall <= (stall_run > 10);
            endcase
        end
    end

    // One item beat, sent in bursts with random gaps; called at a falling edge
    task automatic send_item(input t_in_item req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) :
                                                $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic cmd, input logic [CID_W-1:0] id,
                            input logic [DATA_WIDTH-1:0] word);
        t_in_item req;
        req.cmd         = cmd;
        req.consumer_id = id;
        req.payload     = word;
        send_item(req);
    endtask

    // Stop sending and wait until every status beat has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // Register write; the queue must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        // idle with valid low so a following write starts on a fresh edge
        @(negedge i_clk);
        if (idx == CFG_IDX_MASK)
            cur_mask = val[MASK_W-1:0];
    endtask

    // Mostly registered consumers, the rest any id
    function automatic logic [CID_W-1:0] pick_consumer();
        logic [CID_W-1:0] id;
        id = CID_W'($urandom_range(0, (1 << CID_W) - 1));
        if (cur_mask != '0 && $urandom_range(0, 3) != 0)
            while (!cur_mask[id])
                id = CID_W'($urandom_range(0, (1 << CID_W) - 1));
        return id;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_word();
        unique case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial begin : stimulus
        int                    phase;
        int                    n;
        int                    k;
        int                    add_pct;
        logic [CFG_DATA_W-1:0] mval;
        logic [CFG_DATA_W-1:0] cval;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        burst_left  = 0;
        cur_mask    = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: all consumers, extremes of data and ids
        write_reg(CFG_IDX_MASK, 8'hFF);
        write_reg(CFG_IDX_CAP, 8'd16);
        send_cmd(CMD_GET, 3'd0, 32'h0000_0000);        // get on empty queue
        send_cmd(CMD_ADD, 3'd0, 32'h0000_0000);
        send_cmd(CMD_ADD, 3'd7, 32'hFFFF_FFFF);
        send_cmd(CMD_GET, 3'd7, 32'hFFFF_FFFF);
        send_cmd(CMD_GET, 3'd7, 32'h0000_0000);
        send_cmd(CMD_GET, 3'd7, 32'h5A5A_5A5A);        // nothing left owed
        // no registered consumer: accepted, nothing stored
        settle();
        write_reg(CFG_IDX_MASK, 8'h00);
        send_cmd(CMD_ADD, 3'd3, 32'h1234_5678);
        // capacity zero: always full
        settle();
        write_reg(CFG_IDX_CAP, 8'd0);
        send_cmd(CMD_ADD, 3'd0, 32'hDEAD_BEEF);
        // capacity above depth, new mask; old entries keep their masks
        settle();
        write_reg(CFG_IDX_CAP, 8'hFF);
        write_reg(CFG_IDX_MASK, 8'h81);
        send_cmd(CMD_ADD, 3'd0, 32'hA5A5_A5A5);
        send_cmd(CMD_GET, 3'd0, 32'h0000_0000);
        send_cmd(CMD_GET, 3'd0, 32'h0000_0000);
        send_cmd(CMD_GET, 3'd0, 32'h0000_0000);
        send_cmd(CMD_GET, 3'd7, 32'h0000_0000);        // last reader, entry removed
        // add while full
        settle();
        write_reg(CFG_IDX_CAP, 8'd2);
        send_cmd(CMD_ADD, 3'd1, 32'h8000_0001);
        send_cmd(CMD_GET, 3'd1, 32'h0000_0000);

        // Random phases under differing settings
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            unique case (phase)
                0:       begin mval = 8'hFF; cval = 8'd16; end
                1:       begin mval = 8'h01; cval = 8'd1;  end
                2:       begin mval = 8'h80; cval = 8'hFF; end
                3:       begin mval = 8'h00; cval = 8'd2;  end
                4:       begin mval = 8'h3C; cval = 8'd0;  end
                default: begin
                    mval = CFG_DATA_W'(($urandom_range(0, 2) == 0) ?
                           (8'h01 << $urandom_range(0, 7)) : $urandom_range(0, 255));
                    cval = CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                           $urandom_range(0, 255) : $urandom_range(1, 16));
                end
            endcase
            settle();
            write_reg(CFG_IDX_MASK, mval);
            write_reg(CFG_IDX_CAP, cval);
            // keep adds roughly in step with the reads each entry needs
            add_pct = 100 / (1 + $countones(cur_mask)) + $urandom_range(0, 20) - 10;
            if (add_pct < 5)
                add_pct = 5;
            n = $urandom_range(80, 170);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 99) < add_pct)
                    send_cmd(CMD_ADD, CID_W'($urandom_range(0, (1 << CID_W) - 1)),
                             pick_word());
                else
                    send_cmd(CMD_GET, pick_consumer(), pick_word());
            end
        end

        // Drain and verdict
        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/mcq_pkg.sv
sv/multicast_consumer_queue_unit.sv
sv/mcq_checker.sv
tb/mcq_result_checker.sv
tb/multicast_consumer_queue_unit_test.sv
